/* rtl/vad_pkg.sv */
// Shared types and constants of the voice activity detector.
package vad_pkg;

  localparam int MAX_FRAME_DEF = 4096;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 16;
  localparam int DUR_W    = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int OUT_TDATA_W = 24;

  // Register indexes of the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEECH_TIMEOUT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOINPUT_TIMEOUT = 3'd3;

  // Operation codes carried in tuser
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_RESET  = 1'b1;

  // Detection events
  localparam logic [1:0] EV_NONE       = 2'd0;
  localparam logic [1:0] EV_ACTIVITY   = 2'd1;
  localparam logic [1:0] EV_INACTIVITY = 2'd2;
  localparam logic [1:0] EV_NOINPUT    = 2'd3;

  typedef enum logic [1:0] {
    ST_INACTIVE       = 2'd0,
    ST_GOING_ACTIVE   = 2'd1,
    ST_ACTIVE         = 2'd2,
    ST_GOING_INACTIVE = 2'd3
  } vad_state_t;

  // Handshake between the sequencer and the divider
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/vad_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
module vad_div
  import vad_pkg::*;
#(
  parameter int SW = 29,
  parameter int CW = 13
) (
  input  logic               clk,
  input  logic               rst,
  input  div_ctrl_t          ctrl,
  input  logic [SW-1:0]      dividend,
  input  logic [CW-1:0]      divisor,
  output div_stat_t          stat,
  output logic [LEVEL_W-1:0] quotient
);

  localparam int NW = $clog2(SW + 1);

  logic [CW-1:0] rem;
  logic [SW-1:0] quo;
  logic [NW-1:0] cnt;
  logic [CW-1:0] dvs;
  logic          busy;
  logic          done;

  logic [CW:0] trial;
  logic        fits;

  assign trial = {rem, quo[SW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        // shift in the next dividend bit, subtract where the divisor fits
        if (fits) begin
          rem <= CW'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[CW-1:0];
        end
        quo <= {quo[SW-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == NW'(SW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  // the mean of 16-bit magnitudes never exceeds 32768
  assign quotient  = quo[LEVEL_W-1:0];

endmodule

/* rtl/voice_activity_detector.sv */
// Frame-based energy-threshold voice activity detector, top level.
//
// Audio samples arrive on the s_ stream, one signed 16-bit sample per beat, with
// s_tlast on the last sample of a frame and s_tuser set for a detector reset
// (return to inactive; the sample and tlast of that beat are ignored and the
// partial frame is kept). Absolute values are summed and counted, saturating at
// MAX_FRAME samples per frame, in which case frame_too_long is reported. At
// frame end the mean level is formed by a bit-serial divider and a four-state
// machine (inactive, going active, active, going inactive) is stepped; its
// duration counter adds the frame's sample count, saturates at 2^24-1, and is
// compared with the speech, silence or no-input timeout. One m_ beat goes out
// per frame. A sample that is not the end of a frame, and a reset beat, are
// taken without holding the input. A frame-end sample holds the input while
// the sequencer loads the divider, waits for it and steps the machine; the
// divider retires one quotient bit per cycle. A finished result waits in the
// output register while the next frame is taken in; the block stalls only when
// the next frame ends before that result is taken. Configuration registers are
// written on the cfg_ channel, which is always ready; indexes above 3 are
// dropped.
module voice_activity_detector
  import vad_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // sample stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [SAMPLE_W-1:0]    s_tdata,   // [15:0] sample (signed)
  input  logic                   s_tlast,   // last_in_frame
  input  logic                   s_tuser,   // [0] operation
  // result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // [1:0] event_res, [17:2] level,
                                            // [19:18] detector_state,
                                            // [20] frame_too_long, [23:21] zero
);

  localparam int CW = $clog2(MAX_FRAME + 1);
  localparam int SW = CW + SAMPLE_W;

  typedef enum logic [1:0] {
    C_IDLE,
    C_LOAD,
    C_DIV,
    C_FINISH
  } ctl_t;

  ctl_t ctl;

  // configuration registers
  logic [LEVEL_W-1:0] voice_floor;
  logic [DUR_W-1:0]   speech_hold;
  logic [DUR_W-1:0]   silence_hold;
  logic [DUR_W-1:0]   quiet_hold;

  // detector state
  vad_state_t       machine_state;
  logic [DUR_W-1:0] state_duration;
  logic [SW-1:0]    level_sum;
  logic [CW-1:0]    frame_count;
  logic             overflow_seen;

  div_ctrl_t          div_ctrl;
  div_stat_t          div_stat;
  logic [LEVEL_W-1:0] div_quotient;

  logic               in_beat;
  logic [SAMPLE_W-1:0] mag;
  logic               out_free;
  logic               load_out;

  // frame-end decision
  logic               voice;
  logic [DUR_W:0]     dur_sum;
  logic [DUR_W-1:0]   dur_sat;
  logic [DUR_W-1:0]   limit;
  logic               reached;
  vad_state_t         state_next;
  logic [DUR_W-1:0]   duration_next;
  logic [1:0]         ev_next;

  assign cfg_ready = 1'b1;
  assign s_tready  = (ctl == C_IDLE);
  assign in_beat   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign load_out  = (ctl == C_FINISH) && out_free;

  // 16-bit negate maps -32768 onto 32768
  assign mag = s_tdata[SAMPLE_W-1] ? SAMPLE_W'(-s_tdata) : s_tdata;

  assign div_ctrl.start = (ctl == C_LOAD);

  vad_div #(
    .SW (SW),
    .CW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (level_sum),
    .divisor  (frame_count),
    .stat     (div_stat),
    .quotient (div_quotient)
  );

  assign voice   = div_quotient >= voice_floor;
  assign dur_sum = {1'b0, state_duration} + (DUR_W + 1)'(frame_count);
  assign dur_sat = dur_sum[DUR_W] ? {DUR_W{1'b1}} : dur_sum[DUR_W-1:0];

  // one comparator serves all three timeouts
  always_comb begin
    unique case (machine_state)
      ST_INACTIVE:     limit = quiet_hold;
      ST_GOING_ACTIVE: limit = speech_hold;
      default:         limit = silence_hold;
    endcase
  end

  assign reached = dur_sat >= limit;

  always_comb begin
    state_next    = machine_state;
    duration_next = dur_sat;
    ev_next       = EV_NONE;
    unique case (machine_state)
      ST_INACTIVE: begin
        if (voice) begin
          state_next    = ST_GOING_ACTIVE;
          duration_next = '0;
        end else if (reached) begin
          ev_next = EV_NOINPUT;
        end
      end
      ST_GOING_ACTIVE: begin
        if (!voice) begin
          state_next    = ST_INACTIVE;
          duration_next = '0;
        end else if (reached) begin
          ev_next       = EV_ACTIVITY;
          state_next    = ST_ACTIVE;
          duration_next = '0;
        end
      end
      ST_ACTIVE: begin
        if (!voice) begin
          state_next    = ST_GOING_INACTIVE;
          duration_next = '0;
        end
      end
      ST_GOING_INACTIVE: begin
        if (voice) begin
          state_next    = ST_ACTIVE;
          duration_next = '0;
        end else if (reached) begin
          ev_next       = EV_INACTIVITY;
          state_next    = ST_INACTIVE;
          duration_next = '0;
        end
      end
      default: begin
        state_next = ST_INACTIVE;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      voice_floor  <= '0;
      speech_hold  <= '0;
      silence_hold <= '0;
      quiet_hold   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LEVEL_THRESHOLD: voice_floor  <= cfg_data[LEVEL_W-1:0];
        REG_SPEECH_TIMEOUT:  speech_hold  <= cfg_data[DUR_W-1:0];
        REG_SILENCE_TIMEOUT: silence_hold <= cfg_data[DUR_W-1:0];
        REG_NOINPUT_TIMEOUT: quiet_hold   <= cfg_data[DUR_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // sequencer, accumulators and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl            <= C_IDLE;
      machine_state  <= ST_INACTIVE;
      state_duration <= '0;
      level_sum      <= '0;
      frame_count    <= '0;
      overflow_seen  <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      // a fresh result may replace the one taken at this same edge
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (ctl)
        C_IDLE: begin
          if (in_beat) begin
            if (s_tuser == OP_RESET) begin
              machine_state  <= ST_INACTIVE;
              state_duration <= '0;
            end else begin
              // hold the sums at MAX_FRAME samples and flag the long frame
              if (frame_count < CW'(MAX_FRAME)) begin
                level_sum   <= level_sum + SW'(mag);
                frame_count <= frame_count + 1'b1;
              end else begin
                overflow_seen <= 1'b1;
              end
              if (s_tlast) begin
                ctl <= C_LOAD;
              end
            end
          end
        end
        C_LOAD: begin
          ctl <= C_DIV;
        end
        C_DIV: begin
          if (div_stat.done) begin
            ctl <= C_FINISH;
          end
        end
        C_FINISH: begin
          if (out_free) begin
            machine_state  <= state_next;
            state_duration <= duration_next;
            m_tdata        <= {3'b000, overflow_seen, state_next, div_quotient, ev_next};
            level_sum      <= '0;
            frame_count    <= '0;
            overflow_seen  <= 1'b0;
            ctl            <= C_IDLE;
          end
        end
        default: begin
          ctl <= C_IDLE;
        end
      endcase
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    frame_count <= CW'(MAX_FRAME))
    else $error("frame count beyond MAX_FRAME");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(ctl == C_FINISH))
    else $error("result raised outside frame finish");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (ctl == C_DIV))
    else $error("divider finished while sequencer not waiting");

  a_busy_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (ctl == C_DIV))
    else $error("divider running while sequencer not waiting");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[17:2] <= 16'd32768))
    else $error("level beyond 32768");

  a_activity_state: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[1:0] == EV_ACTIVITY)) |-> (m_tdata[19:18] == ST_ACTIVE))
    else $error("activity event without active state");

endmodule
